/* src/tile_overlay_command_decoder_defines.svh */
// Assertion macros shared by the tile overlay command decoder RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef TILE_OVERLAY_COMMAND_DECODER_DEFINES_SVH
`define TILE_OVERLAY_COMMAND_DECODER_DEFINES_SVH

// Property checked on every rising clock edge while out of reset.
`define TOCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true while out of reset.
`define TOCD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/tocd_pkg.sv */
// Shared types, constants and helpers for the tile overlay command decoder.
// No dependencies; imported by every module of the block.
package tocd_pkg;

  // Stream words and fixed values
  localparam logic [15:0] END_WORD     = 16'hFFFF;  // END in idle, skip in a stripe
  localparam logic [15:0] CUSTOM_WORD  = 16'h8011;
  localparam logic [15:0] TILE_MASK    = 16'h7FFF;
  localparam logic [15:0] WARP_ADDR    = 16'h3BBE;
  localparam logic [15:0] WARP_TILE_LO = 16'h0034;
  localparam logic [15:0] WARP_TILE_HI = 16'h0212;
  localparam logic [7:0]  WARP_LEVEL   = 8'd3;
  localparam logic [15:0] STEP_V       = 16'h0080;
  localparam logic [15:0] STEP_H       = 16'h0002;
  localparam logic [15:0] STEP2_V      = 16'h0100;
  localparam logic [15:0] STEP2_H      = 16'h0004;

  // Stripe command ids (low 7 bits of a command word)
  localparam logic [6:0] ID_STRIPE  = 7'd0;
  localparam logic [6:0] ID_RLE     = 7'd1;
  localparam logic [6:0] ID_RLE_INC = 7'd2;
  localparam logic [6:0] ID_ARB     = 7'd3;

  // Config register indexes
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam logic [1:0] REG_BOSS  = 2'd0;
  localparam logic [1:0] REG_LEVEL = 2'd1;
  localparam logic [1:0] REG_HOLE  = 2'd2;
  localparam logic [1:0] REG_WARP  = 2'd3;

  localparam int unsigned OutDataW = 72;

  typedef struct packed {
    logic        boss_defeated;
    logic [7:0]  progress_level;
    logic [15:0] hole_custom_id;
    logic [15:0] warp_custom_id;
  } cfg_t;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_PLAIN,
    OUT_WARP,
    OUT_STRIPE,
    OUT_ARB,
    OUT_END,
    OUT_RUN
  } out_op_e;

  // Controller -> datapath
  typedef struct packed {
    logic    load_held;    // held tile <= word
    logic    load_header;  // step direction, run size/kind <= word
    logic    load_cursor;  // stripe start: cursor <= word, first flag set
    logic    stripe_step;  // cursor advances (unless first), first flag clears
    logic    load_skip;    // skip count <= word
    logic    dec_skip;
    logic    load_run;     // run start: cursor <= word, remaining <= run size
    out_op_e out_op;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic word_end;
    logic word_cmd;
    logic word_custom;
    logic word_zero;
    logic id_stripe;
    logic id_rle;
    logic id_arb;
    logic hole_match;
    logic warp_match;
    logic boss_defeated;
    logic skip_one;
    logic run_zero;
    logic run_last;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic        first_valid;
    logic [15:0] first_addr;
    logic [15:0] first_tile;
    logic        second_valid;
    logic [15:0] second_addr;
    logic [15:0] second_tile;
    logic        stream_done;
    logic        last;
  } res_t;

  // Tile RAM window 0x2000-0x5FFF
  function automatic logic in_range(logic [15:0] a);
    return (a[15:13] == 3'b001) || (a[15:13] == 3'b010);
  endfunction

endpackage

/* src/tile_overlay_command_decoder.sv */
// Top level of the tile overlay command decoder: stream ports, APB config port.
// Depends on tocd_pkg, tocd_regs, tocd_ctrl and tocd_dpath.
//
// Takes one 16-bit overlay command word per input beat and returns the tile
// writes it causes, two writes per output beat, with tlast on the final beat
// of each word. A write outside 0x2000-0x5FFF keeps its slot but its valid
// bit is low; a missing second write reads as all zeros. An END word in idle
// returns one beat with no writes and tuser (stream_done) high. Words that
// cause no write return no beat. Outside a run, a word is taken whenever the
// output register is free; the word that starts a StripeRLE/StripeRLEINC run
// of N writes is followed by an expansion of ceil(N/2) beats (one pair per
// cycle while tready does not hold the single output register, up to 64
// beats) during which no new word is taken.
// Config registers (APB, 32-bit, byte address 4*i): 0 boss_defeated,
// 1 progress_level, 2 hole_custom_id, 3 warp_custom_id; write only while idle.
module tile_overlay_command_decoder import tocd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [15:0]         s_axis_tdata_i,   // [15:0] stream_word
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] first_valid, [16:1] first_addr, [32:17] first_tile, [33] second_valid,
  // [49:34] second_addr, [65:50] second_tile, [71:66] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tuser_o,   // [0] stream_done
  output logic                m_axis_tlast_o,
  // config
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t    res;

  tocd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // parse FSM; holds off input while a run expands or the result is stalled
  tocd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tocd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (s_axis_tdata_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {6'd0, res.second_tile, res.second_addr, res.second_valid,
                           res.first_tile, res.first_addr, res.first_valid};
  assign m_axis_tuser_o = res.stream_done;
  assign m_axis_tlast_o = res.last;

endmodule

/* src/tocd_regs.sv */
// APB configuration registers of the tile overlay command decoder.
// Depends on tocd_pkg.
module tocd_regs import tocd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boss_defeated  <= 1'b0;
      cfg_q.progress_level <= 8'd0;
      cfg_q.hole_custom_id <= 16'd0;
      cfg_q.warp_custom_id <= 16'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_BOSS:  cfg_q.boss_defeated  <= pwdata[0];
        REG_LEVEL: cfg_q.progress_level <= pwdata[7:0];
        REG_HOLE:  cfg_q.hole_custom_id <= pwdata[15:0];
        REG_WARP:  cfg_q.warp_custom_id <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_BOSS:  prdata = {31'd0, cfg_q.boss_defeated};
      REG_LEVEL: prdata = {24'd0, cfg_q.progress_level};
      REG_HOLE:  prdata = {16'd0, cfg_q.hole_custom_id};
      REG_WARP:  prdata = {16'd0, cfg_q.warp_custom_id};
      default:   prdata = '0;
    endcase
  end

endmodule

/* src/tocd_dpath.sv */
// Datapath: stream word decode, cursor/tile/run/skip registers, result register.
// Depends on tocd_pkg and the assertion macros header.
`include "tile_overlay_command_decoder_defines.svh"
module tocd_dpath import tocd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] word_i,
  input  cfg_t        cfg_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);

  logic [15:0] held_q, held_d;
  logic [15:0] cursor_q, cursor_d;
  logic        first_q, first_d;
  logic        vert_q, vert_d;
  logic        inc_q, inc_d;
  logic [6:0]  len_q, len_d;
  logic [6:0]  rem_q, rem_d;
  logic [15:0] skip_q, skip_d;
  logic        out_valid_q;
  res_t        res_q, res_d;

  logic [15:0] step, step2, cursor_next;
  logic        out_free;
  logic        has1, has2;
  logic [15:0] a1, t1, a2, t2;

  assign step        = vert_q ? STEP_V : STEP_H;
  assign step2       = vert_q ? STEP2_V : STEP2_H;
  assign cursor_next = first_q ? cursor_q : cursor_q + step;
  assign out_free    = !out_valid_q || res_ready_i;

  // Status toward the controller
  always_comb begin
    sts_o.word_end      = (word_i == END_WORD);
    sts_o.word_cmd      = word_i[15];
    sts_o.word_custom   = (word_i == CUSTOM_WORD);
    sts_o.word_zero     = (word_i == 16'd0);
    sts_o.id_stripe     = (word_i[6:0] == ID_STRIPE);
    sts_o.id_rle        = (word_i[6:0] == ID_RLE) || (word_i[6:0] == ID_RLE_INC);
    sts_o.id_arb        = (word_i[6:0] == ID_ARB);
    sts_o.hole_match    = (word_i == cfg_i.hole_custom_id);
    sts_o.warp_match    = (word_i == cfg_i.warp_custom_id);
    sts_o.boss_defeated = cfg_i.boss_defeated;
    sts_o.skip_one      = (skip_q == 16'd1);
    sts_o.run_zero      = (len_q == 7'd0);
    sts_o.run_last      = (rem_q <= 7'd2);  // one or two writes left
    sts_o.out_free      = out_free;
  end

  // Working registers
  always_comb begin
    held_d   = held_q;
    cursor_d = cursor_q;
    first_d  = first_q;
    vert_d   = vert_q;
    inc_d    = inc_q;
    len_d    = len_q;
    rem_d    = rem_q;
    skip_d   = skip_q;
    if (cmd_i.load_held) begin
      held_d = word_i;
    end
    if (cmd_i.load_header) begin
      vert_d = word_i[7];
      if (sts_o.id_rle) begin
        len_d = word_i[14:8];
        inc_d = (word_i[6:0] == ID_RLE_INC);
      end
    end
    if (cmd_i.load_cursor) begin
      cursor_d = word_i;
      first_d  = 1'b1;
    end
    if (cmd_i.stripe_step) begin
      cursor_d = cursor_next;
      first_d  = 1'b0;
    end
    if (cmd_i.load_skip) begin
      skip_d = word_i;
    end
    if (cmd_i.dec_skip) begin
      skip_d = skip_q - 16'd1;
    end
    if (cmd_i.load_run) begin
      cursor_d = word_i;
      rem_d    = len_q;
    end
    // one pair of a run per beat
    if (cmd_i.out_op == OUT_RUN) begin
      cursor_d = cursor_q + step2;
      held_d   = held_q + {14'd0, inc_q, 1'b0};
      rem_d    = rem_q - 7'd2;
    end
  end

  // Result selection
  always_comb begin
    has1 = 1'b1;
    has2 = 1'b0;
    a1   = '0;
    t1   = '0;
    a2   = '0;
    t2   = '0;
    res_d = res_q;
    unique case (cmd_i.out_op)
      OUT_PLAIN: begin
        a1 = word_i;
        t1 = held_q;
      end
      OUT_WARP: begin
        a1 = WARP_ADDR;
        t1 = (cfg_i.progress_level < WARP_LEVEL) ? WARP_TILE_LO : WARP_TILE_HI;
      end
      OUT_STRIPE: begin
        a1 = cursor_next;
        t1 = word_i & TILE_MASK;
      end
      OUT_ARB: begin
        a1 = word_i & TILE_MASK;
        t1 = held_q;
      end
      OUT_RUN: begin
        a1   = cursor_q;
        t1   = held_q;
        has2 = (rem_q[6:1] != 6'd0);
        if (has2) begin
          a2 = cursor_q + step;
          t2 = held_q + {15'd0, inc_q};
        end
      end
      OUT_END: has1 = 1'b0;
      OUT_NONE: has1 = 1'b0;
      default: has1 = 1'b0;
    endcase
    if (cmd_i.out_op != OUT_NONE) begin
      res_d.first_valid  = has1 && in_range(a1);
      res_d.first_addr   = a1;
      res_d.first_tile   = t1;
      res_d.second_valid = has2 && in_range(a2);
      res_d.second_addr  = a2;
      res_d.second_tile  = t2;
      res_d.stream_done  = (cmd_i.out_op == OUT_END);
      res_d.last         = (cmd_i.out_op != OUT_RUN) || sts_o.run_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      cursor_q    <= '0;
      first_q     <= 1'b1;
      vert_q      <= 1'b0;
      inc_q       <= 1'b0;
      len_q       <= '0;
      rem_q       <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q   <= held_d;
      cursor_q <= cursor_d;
      first_q  <= first_d;
      vert_q   <= vert_d;
      inc_q    <= inc_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      skip_q   <= skip_d;
      if (cmd_i.out_op != OUT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  `TOCD_ASSERT(a_load_free, (cmd_i.out_op != OUT_NONE) |-> out_free, "result overwritten")
  `TOCD_ASSERT(a_first_rng,
    (out_valid_q && res_q.first_valid) |-> in_range(res_q.first_addr),
    "first write out of window")
  `TOCD_ASSERT(a_second_rng,
    (out_valid_q && res_q.second_valid) |-> in_range(res_q.second_addr),
    "second write out of window")
  `TOCD_ASSERT_NEVER(a_end_writes,
    out_valid_q && res_q.stream_done &&
    (res_q.first_valid || res_q.second_valid || !res_q.last),
    "END beat carries writes")

endmodule

/* src/tocd_ctrl.sv */
// Controller: parse-mode state machine of the tile overlay command decoder.
// Depends on tocd_pkg; drives the datapath through dp_cmd_t.
module tocd_ctrl import tocd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLAIN_POS,
    ST_CUSTOM_ID,
    ST_HOLE_COUNT,
    ST_SKIP,
    ST_STRIPE_START,
    ST_STRIPE_TILE,
    ST_RLE_TILE,
    ST_RLE_POS,
    ST_ARB_TILE,
    ST_ARB_POS,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q != ST_RUN) && sts_i.out_free;
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_op = OUT_NONE;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        if (sts_i.word_end) begin
          cmd_o.out_op = OUT_END;
        end else if (!sts_i.word_cmd) begin
          cmd_o.load_held = 1'b1;
          state_d = ST_PLAIN_POS;
        end else if (sts_i.word_custom) begin
          state_d = ST_CUSTOM_ID;
        end else begin
          cmd_o.load_header = 1'b1;
          if (sts_i.id_stripe) begin
            state_d = ST_STRIPE_START;
          end else if (sts_i.id_rle) begin
            state_d = ST_RLE_TILE;
          end else if (sts_i.id_arb) begin
            state_d = ST_ARB_TILE;
          end
        end
      end
      ST_PLAIN_POS: if (accept) begin
        cmd_o.out_op = OUT_PLAIN;
        state_d = ST_IDLE;
      end
      ST_CUSTOM_ID: if (accept) begin
        if (sts_i.hole_match) begin
          state_d = ST_HOLE_COUNT;
        end else begin
          if (sts_i.warp_match) cmd_o.out_op = OUT_WARP;
          state_d = ST_IDLE;
        end
      end
      ST_HOLE_COUNT: if (accept) begin
        if (!sts_i.boss_defeated && !sts_i.word_zero) begin
          cmd_o.load_skip = 1'b1;
          state_d = ST_SKIP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SKIP: if (accept) begin
        cmd_o.dec_skip = 1'b1;
        if (sts_i.skip_one) state_d = ST_IDLE;
      end
      ST_STRIPE_START: if (accept) begin
        cmd_o.load_cursor = 1'b1;
        state_d = ST_STRIPE_TILE;
      end
      ST_STRIPE_TILE: if (accept) begin
        cmd_o.stripe_step = 1'b1;
        if (!sts_i.word_end) begin
          cmd_o.out_op = OUT_STRIPE;
          if (sts_i.word_cmd) state_d = ST_IDLE;
        end
      end
      ST_RLE_TILE: if (accept) begin
        cmd_o.load_held = 1'b1;
        state_d = ST_RLE_POS;
      end
      ST_RLE_POS: if (accept) begin
        cmd_o.load_run = 1'b1;
        state_d = sts_i.run_zero ? ST_IDLE : ST_RUN;
      end
      ST_ARB_TILE: if (accept) begin
        cmd_o.load_held = 1'b1;
        state_d = ST_ARB_POS;
      end
      ST_ARB_POS: if (accept) begin
        cmd_o.out_op = OUT_ARB;
        if (sts_i.word_cmd) state_d = ST_IDLE;
      end
      ST_RUN: if (sts_i.out_free) begin
        cmd_o.out_op = OUT_RUN;
        if (sts_i.run_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* tb/sv/tb_tile_overlay_command_decoder.sv */
// Testbench for the tile overlay command decoder: directed and random command
// streams, checked beat by beat against a behavioral decoder kept in this file.
// Depends on tocd_pkg and the tile_overlay_command_decoder RTL.
module tb_tile_overlay_command_decoder;
  import tocd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYCLES = 80;   // longest run expansion plus margin
  localparam logic [15:0] WIN_LO = 16'h2000;     // tile RAM window
  localparam logic [15:0] WIN_HI = 16'h6000;

  // Decoder parse states as the behavioral model sees them
  typedef enum logic [3:0] {
    M_IDLE, M_PLAIN_POS, M_CUSTOM_ID, M_HOLE_COUNT, M_SKIP, M_STRIPE_START,
    M_STRIPE_TILE, M_RLE_TILE, M_RLE_POS, M_ARB_TILE, M_ARB_POS
  } parse_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [15:0]         s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  tile_overlay_command_decoder dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the config registers and the decoder state
  cfg_t        shadow_cfg;
  parse_e      mode;
  logic [15:0] held_tile;
  logic [15:0] cursor;
  logic        first_step;
  logic        vertical;
  logic        run_inc;
  logic [6:0]  run_len;
  logic [15:0] skip_left;

  res_t        write_beats[$];   // predicted result beats, oldest first
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  logic        no_gaps = 1'b0;   // suppresses idling on both sides

  function automatic logic in_window(logic [15:0] a);
    return (a >= WIN_LO) && (a < WIN_HI);
  endfunction

  // Behavioral decode of one stream word; appends the beats it causes.
  function automatic void decode_word(logic [15:0] w);
    logic [15:0] wr_addr[$];
    logic [15:0] wr_tile[$];
    logic [15:0] step;
    logic        done;
    res_t        beat;
    done = 1'b0;
    step = vertical ? STEP_V : STEP_H;
    case (mode)
      M_PLAIN_POS: begin
        wr_addr.push_back(w); wr_tile.push_back(held_tile);
        mode = M_IDLE;
      end
      M_CUSTOM_ID: begin
        mode = M_IDLE;
        // hole id wins when both ids are equal
        if (w == shadow_cfg.hole_custom_id) begin
          mode = M_HOLE_COUNT;
        end else if (w == shadow_cfg.warp_custom_id) begin
          wr_addr.push_back(WARP_ADDR);
          wr_tile.push_back(shadow_cfg.progress_level < WARP_LEVEL ? WARP_TILE_LO
                                                                   : WARP_TILE_HI);
        end
      end
      M_HOLE_COUNT: begin
        mode = M_IDLE;
        if (!shadow_cfg.boss_defeated && w != '0) begin
          skip_left = w;
          mode = M_SKIP;
        end
      end
      M_SKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == '0) mode = M_IDLE;
      end
      M_STRIPE_START: begin
        cursor = w;
        first_step = 1'b1;
        mode = M_STRIPE_TILE;
      end
      M_STRIPE_TILE: begin
        if (!first_step) cursor = cursor + step;
        first_step = 1'b0;
        if (w != END_WORD) begin
          wr_addr.push_back(cursor);
          if (w[15]) begin
            wr_tile.push_back(w & TILE_MASK);
            mode = M_IDLE;
          end else begin
            wr_tile.push_back(w);
          end
        end
      end
      M_RLE_TILE: begin
        held_tile = w;
        mode = M_RLE_POS;
      end
      M_RLE_POS: begin
        cursor = w;
        for (int i = 0; i < int'(run_len); i++) begin
          if (i != 0) begin
            cursor = cursor + step;
            if (run_inc) held_tile = held_tile + 16'd1;
          end
          wr_addr.push_back(cursor); wr_tile.push_back(held_tile);
        end
        mode = M_IDLE;
      end
      M_ARB_TILE: begin
        held_tile = w;
        mode = M_ARB_POS;
      end
      M_ARB_POS: begin
        wr_tile.push_back(held_tile);
        if (w[15]) begin
          wr_addr.push_back(w & TILE_MASK);
          mode = M_IDLE;
        end else begin
          wr_addr.push_back(w);
        end
      end
      default: begin
        mode = M_IDLE;
        if (w == END_WORD) begin
          done = 1'b1;
        end else if (!w[15]) begin
          held_tile = w;
          mode = M_PLAIN_POS;
        end else if (w == CUSTOM_WORD) begin
          mode = M_CUSTOM_ID;
        end else begin
          vertical = w[7];
          case (w[6:0])
            ID_STRIPE: mode = M_STRIPE_START;
            ID_RLE, ID_RLE_INC: begin
              run_len = w[14:8];
              run_inc = (w[6:0] == ID_RLE_INC);
              mode = M_RLE_TILE;
            end
            ID_ARB: mode = M_ARB_TILE;
            default: ;  // unknown stripe id: ignored
          endcase
        end
      end
    endcase

    if (done) begin
      beat = '0;
      beat.stream_done = 1'b1;
      beat.last = 1'b1;
      write_beats.push_back(beat);
    end
    // two writes per beat, odd tail leaves the second slot zero
    for (int k = 0; k < wr_addr.size(); k += 2) begin
      beat = '0;
      beat.first_valid = in_window(wr_addr[k]);
      beat.first_addr  = wr_addr[k];
      beat.first_tile  = wr_tile[k];
      if (k + 1 < wr_addr.size()) begin
        beat.second_valid = in_window(wr_addr[k+1]);
        beat.second_addr  = wr_addr[k+1];
        beat.second_tile  = wr_tile[k+1];
      end
      beat.last = (k + 2 >= wr_addr.size());
      write_beats.push_back(beat);
    end
  endfunction

  // ---------------------------------------------------------------- result side
  // tready idles at random unless a no-gap stretch is running.
  always @(posedge clk_i) begin
    m_axis_tready_i <= no_gaps || ($urandom_range(99) >= 29);
  end

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %h, actual %h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Every accepted beat is compared with the oldest prediction.
  always @(posedge clk_i) begin
    res_t exp_beat;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (write_beats.size() == 0) begin
        $error("unexpected result beat: tdata %h tuser %b tlast %b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        exp_beat = write_beats.pop_front();
        check_field("first_valid",  16'(exp_beat.first_valid),  16'(m_axis_tdata_o[0]));
        check_field("first_addr",   exp_beat.first_addr,   m_axis_tdata_o[16:1]);
        check_field("first_tile",   exp_beat.first_tile,   m_axis_tdata_o[32:17]);
        check_field("second_valid", 16'(exp_beat.second_valid), 16'(m_axis_tdata_o[33]));
        check_field("second_addr",  exp_beat.second_addr,  m_axis_tdata_o[49:34]);
        check_field("second_tile",  exp_beat.second_tile,  m_axis_tdata_o[65:50]);
        check_field("stream_done",  16'(exp_beat.stream_done),  16'(m_axis_tuser_o));
        check_field("last",         16'(exp_beat.last),         16'(m_axis_tlast_o));
      end
    end
  end

  // Watchdog: a hang or a lost beat ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ----------------------------------------------------------------- word side
  // One beat on the input stream. Here tvalid only drops for a random idle gap,
  // so back-to-back beats never lower and raise it in the same step.
  task automatic send_word(logic [15:0] w);
    int unsigned gap;
    if (!no_gaps && $urandom_range(99) < 29) begin
      s_axis_tvalid_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    decode_word(w);
    words_sent++;
  endtask

  // Sender holds off until every predicted beat has been taken.
  task automatic hold_until_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (write_beats.size() != 0);
  endtask

  // APB write then read-back, after waiting for the decoder to drain.
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= CfgDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_BOSS:  shadow_cfg.boss_defeated  = value[0];
      REG_LEVEL: shadow_cfg.progress_level = value[7:0];
      REG_HOLE:  shadow_cfg.hole_custom_id = value;
      default:   shadow_cfg.warp_custom_id = value;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== CfgDataW'(value)) begin
      $error("register %0d readback: expected %h, actual %h", idx, value, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(logic boss, logic [7:0] level, logic [15:0] hole,
                                logic [15:0] warp);
    write_reg(REG_BOSS, {15'd0, boss});
    write_reg(REG_LEVEL, {8'd0, level});
    write_reg(REG_HOLE, hole);
    write_reg(REG_WARP, warp);
  endtask

  // Position biased into the tile window, with the rest of the space as well.
  function automatic logic [15:0] random_pos();
    if ($urandom_range(9) < 7) return 16'($urandom_range(WIN_LO, WIN_HI - 1));
    return 16'($urandom);
  endfunction

  // ------------------------------------------------------------------- tests
  task automatic test_plain_pairs();
    send_word(16'h0000); send_word(WIN_LO);          // lowest tile, window start
    send_word(16'h7FFF); send_word(16'h1FFF);        // highest tile, below window
    send_word(16'h5A5A); send_word(WIN_HI);          // first address past window
  endtask

  task automatic test_stripes();
    // vertical stripe from the top of the space: cursor wraps, one skipped slot
    send_word({1'b1, 7'h00, 1'b1, ID_STRIPE});
    send_word(16'hFFFE);
    send_word(16'h0005);
    send_word(END_WORD);
    send_word(16'h8123);
    // horizontal stripe inside the window, stopped at once
    send_word({1'b1, 7'h7E, 1'b0, ID_STRIPE});
    send_word(16'h5FFE);
    send_word(16'hFFFE);
  endtask

  task automatic test_runs();
    send_word({1'b1, 7'd0, 1'b0, ID_RLE});           // zero-size run
    send_word(16'h1234);
    send_word(16'h3000);
    send_word({1'b1, 7'd127, 1'b1, ID_RLE_INC});     // longest run, tile wraps
    send_word(16'hFFFF);
    send_word(16'h2000);
    send_word({1'b1, 7'd3, 1'b0, ID_RLE});           // odd count leaves an empty slot
    send_word(16'h7FFF);
    send_word(16'h5FFC);
  endtask

  task automatic test_arb_copy();
    send_word({1'b1, 7'h00, 1'b0, ID_ARB});
    send_word(16'h0042);
    send_word(16'h5FFF);
    send_word(16'hE000);                             // last position, masked to 0x6000
  endtask

  task automatic test_unknown_ids();
    send_word({1'b1, 8'h00, 7'd4});
    send_word({1'b1, 8'hFE, 7'h7F});
  endtask

  task automatic test_custom();
    // hole block skipped while boss flag is clear; the skipped END is blind
    send_word(CUSTOM_WORD); send_word(shadow_cfg.hole_custom_id);
    send_word(16'h0002); send_word(END_WORD); send_word(CUSTOM_WORD);
    send_word(CUSTOM_WORD); send_word(shadow_cfg.warp_custom_id);
    send_word(CUSTOM_WORD); send_word(16'h1234);     // unknown custom id
    send_word(END_WORD);
  endtask

  task automatic test_config_extremes();
    // equal ids: hole wins; boss defeated so nothing is skipped
    write_all_regs(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_word(CUSTOM_WORD); send_word(16'hFFFF); send_word(16'h0003);
    send_word(16'h1111); send_word(16'h4000);
    // warp tile on both sides of the level threshold
    write_reg(REG_WARP, 16'h0000);
    write_reg(REG_LEVEL, {8'd0, WARP_LEVEL});
    send_word(CUSTOM_WORD); send_word(16'h0000);
    write_reg(REG_LEVEL, {8'd0, WARP_LEVEL - 8'd1});
    send_word(CUSTOM_WORD); send_word(16'h0000);
    // hole count of zero skips nothing
    write_reg(REG_BOSS, 16'h0000);
    send_word(CUSTOM_WORD); send_word(16'hFFFF); send_word(16'h0000);
    send_word(END_WORD);
  endtask

  // One command with random content; a few are plain noise.
  task automatic send_random_command();
    int unsigned pick;
    int unsigned n;
    logic [6:0]  size;
    logic [15:0] w;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_word({1'b0, 15'($urandom)});
      send_word(random_pos());
    end else if (pick < 27) begin
      send_word({1'b1, 8'($urandom), ID_STRIPE});
      send_word(random_pos());
      n = $urandom_range(0, 5);
      repeat (n) send_word(($urandom_range(4) == 0) ? END_WORD : {1'b0, 15'($urandom)});
      w = {1'b1, 15'($urandom)};
      send_word(w == END_WORD ? 16'h8000 : w);
    end else if (pick < 47) begin
      size = ($urandom_range(19) == 0) ? 7'd127 : 7'($urandom_range(0, 9));
      send_word({1'b1, size, 1'($urandom), $urandom_range(1) ? ID_RLE : ID_RLE_INC});
      send_word(16'($urandom));
      send_word(random_pos());
    end else if (pick < 60) begin
      send_word({1'b1, 8'($urandom), ID_ARB});
      send_word(16'($urandom));
      n = $urandom_range(0, 4);
      repeat (n) send_word(random_pos() & TILE_MASK);
      send_word(random_pos() | ~TILE_MASK);
    end else if (pick < 78) begin
      send_word(CUSTOM_WORD);
      pick = $urandom_range(9);
      send_word(pick < 4 ? shadow_cfg.hole_custom_id :
                pick < 8 ? shadow_cfg.warp_custom_id : 16'($urandom));
      if (mode == M_HOLE_COUNT) begin
        send_word(16'($urandom_range(0, 4)));
        while (mode == M_SKIP) send_word(16'($urandom));
      end
    end else if (pick < 86) begin
      send_word(END_WORD);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) send_word(16'($urandom));
    end
  endtask

  task automatic test_random();
    int unsigned target;
    int unsigned level_pick;
    for (int phase = 0; phase < 4; phase++) begin
      level_pick = $urandom_range(4);
      write_all_regs(1'($urandom),
                     level_pick == 0 ? 8'd0 : level_pick == 1 ? 8'd255 :
                     8'($urandom_range(1, 4)),
                     $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3)),
                     $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3)));
      no_gaps = (phase == 2);            // one long stretch without idling
      target = words_sent + 12;
      while (words_sent < target) begin
        send_random_command();
        if ($urandom_range(24) == 0) hold_until_drained();
      end
      no_gaps = 1'b0;
    end
  endtask

  // -------------------------------------------------------------------- main
  initial begin
    shadow_cfg = '{boss_defeated: 1'b0, progress_level: 8'd0,
                   hole_custom_id: 16'h0000, warp_custom_id: 16'h0001};
    mode = M_IDLE;
    held_tile = '0; cursor = '0; first_step = 1'b1;
    vertical = 1'b0; run_inc = 1'b0; run_len = '0; skip_left = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_all_regs(1'b0, 8'd0, 16'h0000, 16'h0001);
    test_plain_pairs();
    test_stripes();
    test_runs();
    test_arb_copy();
    test_unknown_ids();
    test_custom();
    test_config_extremes();
    test_random();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
